// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files of the line framer queue.
// Needs a clock and a reset signal named clock and reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and synchronous reset
`define LFQ_ASSERT_CR(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the block clock and reset
`define LFQ_ASSERT(lbl, prop, msg) `LFQ_ASSERT_CR(lbl, clock, reset, prop, msg)

`endif

// ===== src/lfq_pkg.sv =====
// Package of the CRLF line framer queue: sizes, field widths, codes and types.
// No dependencies; used by every other file of the block except assert_macros.svh.
`default_nettype none

package lfq_pkg;

   // Frame ring geometry
   localparam int FRAME_BYTES = 64;
   localparam int QUEUE_SLOTS = 4;
   localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam int ADDR_W      = SLOT_W + IDX_W;
   localparam int RAM_DEPTH   = 2 ** ADDR_W;
   localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
   localparam int CNT_W       = $clog2(QUEUE_SLOTS + 1);

   // Field widths of the channels
   localparam int BYTE_W    = 8;
   localparam int TIME_W    = 32;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int OUT_LEN_W = 6;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_GAP = '0;
   localparam logic [TIME_W-1:0]     GAP_RESET   = 32'd1000;

   // Line framing characters
   localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;

   typedef enum logic {
      ACT_BYTE  = 1'b0,
      ACT_DRAIN = 1'b1
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE   = 2'd0,
      KIND_LINE   = 2'd1,
      KIND_NOLINE = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_OVERFLOW = 2'd1,
      STAT_DROPPED  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EMIT
   } state_type;

   // Line RAM access from the control logic
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

// ===== src/lfq_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on lfq_pkg for the field widths.
`default_nettype none

interface lfq_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [lfq_pkg::BYTE_W-1:0]  byte_value;
   logic [lfq_pkg::TIME_W-1:0]  now_ms;

   modport source (output valid, action, byte_value, now_ms, input ready);
   modport sink   (input valid, action, byte_value, now_ms, output ready);
endinterface

interface lfq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lfq_pkg::KIND_W-1:0]    result_kind;
   logic [lfq_pkg::STATUS_W-1:0]  status;
   logic [lfq_pkg::BYTE_W-1:0]    data_byte;
   logic [lfq_pkg::OUT_LEN_W-1:0] line_length;
   logic                          last;

   modport source (output valid, result_kind, status, data_byte, line_length, last,
                   input ready);
   modport sink   (input valid, result_kind, status, data_byte, line_length, last,
                   output ready);
endinterface

`default_nettype wire

// ===== src/lfq_line_ram.sv =====
// Line store: one write port, one read port with registered read data.
// Depends on lfq_pkg for geometry and the request struct.
`default_nettype none

module lfq_line_ram (
   input  logic                        clock,
   input  lfq_pkg::ram_req_type        ram_req,
   output logic [lfq_pkg::BYTE_W-1:0]  rd_data
);
   import lfq_pkg::*;

   logic [BYTE_W-1:0] mem [RAM_DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Read port, registered: data in the cycle after the request
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data <= mem[ram_req.rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/lfq_csr.sv =====
// Register port: holds the inter-byte gap timeout, APB-style access.
// Depends on lfq_pkg for the register index and reset value.
`default_nettype none

module lfq_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lfq_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lfq_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lfq_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [lfq_pkg::TIME_W-1:0]      gap_timeout
);
   import lfq_pkg::*;

   logic [TIME_W-1:0] gap_ff;
   logic              gap_sel;
   logic              gap_wr;

   // Word-aligned register decode
   assign gap_sel = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_GAP);
   assign gap_wr  = psel && penable && pwrite && gap_sel;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= GAP_RESET;
      end else if (gap_wr) begin
         gap_ff <= pwdata[TIME_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (gap_sel) begin
         prdata = CSR_DATA_W'(gap_ff);
      end
   end

   assign gap_timeout = gap_ff;

endmodule

`default_nettype wire

// ===== src/crlf_line_framer_queue.sv =====
// Top level of the CRLF line framer: byte framing, frame ring control,
// drain sequencer and response register. Uses lfq_pkg, lfq_if, lfq_csr, lfq_line_ram.
//
//   channel   direction  handshake        word
//   req_bus   in         valid/ready      action, byte_value, now_ms
//   rsp_bus   out        valid/ready      result_kind, status, data_byte, line_length, last
//   psel..    in/out     APB, pready=1    gap_timeout_ms at byte address 0
//
// A byte word is one read-modify-write of the frame state and one line RAM write;
// a new byte is taken every cycle the response register frees and no drain runs.
// A drain of an N-byte line reads each byte through the single read port in S_READ
// and then emits it in S_EMIT; an empty ring or empty line answers with one word.
// Synchronous reset clears control state; the line RAM is not cleared.
// A stalled response holds the response register and blocks new requests.
`default_nettype none

module crlf_line_framer_queue (
   input  logic                            clock,
   input  logic                            reset,
   lfq_req_if.sink                         req_bus,
   lfq_rsp_if.source                       rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lfq_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lfq_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lfq_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import lfq_pkg::*;

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : s + 1'b1;
   endfunction

   logic [TIME_W-1:0] gap_timeout;
   logic [BYTE_W-1:0] ram_rd_data;
   ram_req_type       ram_req;

   // Frame and ring state
   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  active_len_ff;
   logic [SLOT_W-1:0] write_slot_ff;
   logic [SLOT_W-1:0] read_slot_ff;
   logic [CNT_W-1:0]  ready_cnt_ff;
   logic [BYTE_W-1:0] prev_byte_ff;
   logic              ovf_ff;
   logic [TIME_W-1:0] last_ms_ff;
   logic [LEN_W-1:0]  stored_len_ff [QUEUE_SLOTS];

   // Drain sequencer
   logic [SLOT_W-1:0] drn_slot_ff;
   logic [LEN_W-1:0]  drn_idx_ff;
   logic [LEN_W-1:0]  drn_len_ff;

   // Response register
   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff;
   status_type           rsp_status_ff;
   logic [BYTE_W-1:0]    rsp_data_ff;
   logic [OUT_LEN_W-1:0] rsp_len_ff;
   logic                 rsp_last_ff;

   logic              out_free;
   logic              accept;
   logic              is_byte;
   logic              is_drain;
   logic              ring_empty;
   logic [TIME_W-1:0] elapsed;
   logic              gap_hit;
   logic [LEN_W-1:0]  eff_len;
   logic              eff_ovf;
   logic [BYTE_W-1:0] eff_prev;
   logic              line_end;
   logic              ring_room;
   logic [LEN_W-1:0]  trim_len;
   logic              commit;
   logic              store_byte;
   status_type        byte_status;
   logic [LEN_W-1:0]  nx_len;
   logic              nx_ovf;
   logic [BYTE_W-1:0] nx_prev;
   logic [LEN_W-1:0]  head_len_raw;
   logic [LEN_W-1:0]  head_len;
   logic              drain_start;
   logic              drain_last;
   logic              emit_load;
   logic              req_ready;
   logic              ram_rd_en;

   lfq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .gap_timeout (gap_timeout)
   );

   lfq_line_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   // Handshake
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = req_ready;
   assign accept        = req_bus.valid && req_ready;
   assign is_byte       = accept && (req_bus.action == ACT_BYTE);
   assign is_drain      = accept && (req_bus.action == ACT_DRAIN);
   assign ring_empty    = (ready_cnt_ff == '0);

   // Inter-byte gap, modulo 2^32
   assign elapsed = req_bus.now_ms - last_ms_ff;
   assign gap_hit = (elapsed > gap_timeout);

   // Byte framing: gap restart, CR LF line end, overflow, append
   always_comb begin
      eff_len     = gap_hit ? '0 : active_len_ff;
      eff_ovf     = gap_hit ? 1'b0 : ovf_ff;
      eff_prev    = gap_hit ? '0 : prev_byte_ff;
      line_end    = (eff_prev == BYTE_CR) && (req_bus.byte_value == BYTE_LF);
      ring_room   = (ready_cnt_ff < CNT_W'(QUEUE_SLOTS - 1));
      trim_len    = (eff_len != '0) ? eff_len - LEN_W'(1) : '0;
      commit      = 1'b0;
      store_byte  = 1'b0;
      byte_status = STAT_OK;
      nx_len      = eff_len;
      nx_ovf      = eff_ovf;
      nx_prev     = req_bus.byte_value;
      if (line_end) begin
         nx_prev = '0;
         nx_len  = '0;
         nx_ovf  = 1'b0;
         if (!eff_ovf && ring_room) begin
            commit = 1'b1;
         end else begin
            byte_status = STAT_DROPPED;
         end
      end else if (eff_ovf) begin
         byte_status = STAT_OVERFLOW;
      end else if (eff_len >= LEN_W'(FRAME_BYTES)) begin
         nx_ovf      = 1'b1;
         byte_status = STAT_OVERFLOW;
      end else begin
         store_byte = 1'b1;
         nx_len     = eff_len + LEN_W'(1);
      end
   end

   // Oldest ready line
   assign head_len_raw = stored_len_ff[read_slot_ff];
   assign head_len     = (head_len_raw > LEN_W'(FRAME_BYTES - 1)) ?
                         LEN_W'(FRAME_BYTES - 1) : head_len_raw;
   assign drain_start  = is_drain && !ring_empty;
   assign drain_last   = ((drn_idx_ff + LEN_W'(1)) == drn_len_ff);

   // Line RAM access
   always_comb begin
      ram_req.wr_en   = is_byte && store_byte;
      ram_req.wr_addr = {write_slot_ff, eff_len[IDX_W-1:0]};
      ram_req.wr_data = req_bus.byte_value;
      ram_req.rd_en   = ram_rd_en;
      ram_req.rd_addr = {drn_slot_ff, drn_idx_ff[IDX_W-1:0]};
   end

   // Drain sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (drain_start && (head_len != '0)) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = drain_last ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Drain sequencer: outputs
   always_comb begin
      req_ready = 1'b0;
      ram_rd_en = 1'b0;
      emit_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = out_free;
         end
         S_READ: begin
            ram_rd_en = 1'b1;
         end
         S_EMIT: begin
            emit_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_len_ff <= '0;
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         ready_cnt_ff  <= '0;
         prev_byte_ff  <= '0;
         ovf_ff        <= 1'b0;
         last_ms_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (is_byte) begin
            active_len_ff <= nx_len;
            ovf_ff        <= nx_ovf;
            prev_byte_ff  <= nx_prev;
            last_ms_ff    <= req_bus.now_ms;
            if (commit) begin
               write_slot_ff <= slot_next(write_slot_ff);
               ready_cnt_ff  <= ready_cnt_ff + CNT_W'(1);
            end
         end
         if (drain_start) begin
            read_slot_ff <= slot_next(read_slot_ff);
            ready_cnt_ff <= ready_cnt_ff - CNT_W'(1);
         end
      end
   end

   // Committed line lengths
   always_ff @(posedge clock) begin
      if (is_byte && commit) begin
         stored_len_ff[write_slot_ff] <= trim_len;
      end
   end

   // Drain counters
   always_ff @(posedge clock) begin
      if (drain_start) begin
         drn_slot_ff <= read_slot_ff;
         drn_idx_ff  <= '0;
         drn_len_ff  <= head_len;
      end else if (emit_load && !drain_last) begin
         drn_idx_ff <= drn_idx_ff + LEN_W'(1);
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (is_byte || (is_drain && (ring_empty || (head_len == '0))) || emit_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (is_byte) begin
         rsp_kind_ff   <= KIND_BYTE;
         rsp_status_ff <= byte_status;
         rsp_data_ff   <= '0;
         rsp_len_ff    <= '0;
         rsp_last_ff   <= 1'b1;
      end else if (is_drain && (ring_empty || (head_len == '0))) begin
         rsp_kind_ff   <= ring_empty ? KIND_NOLINE : KIND_LINE;
         rsp_status_ff <= STAT_OK;
         rsp_data_ff   <= '0;
         rsp_len_ff    <= '0;
         rsp_last_ff   <= 1'b1;
      end else if (emit_load) begin
         rsp_kind_ff   <= KIND_LINE;
         rsp_status_ff <= STAT_OK;
         rsp_data_ff   <= ram_rd_data;
         rsp_len_ff    <= OUT_LEN_W'(drn_len_ff);
         rsp_last_ff   <= drain_last;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_kind = rsp_kind_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.data_byte   = rsp_data_ff;
   assign rsp_bus.line_length = rsp_len_ff;
   assign rsp_bus.last        = rsp_last_ff;

endmodule

`default_nettype wire

// ===== src/lfq_checker.sv =====
// Port-level checker for the CRLF line framer queue, bound to the top level.
// Depends on lfq_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module lfq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_action,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [lfq_pkg::KIND_W-1:0]      rsp_kind,
   input logic [lfq_pkg::STATUS_W-1:0]    rsp_status,
   input logic [lfq_pkg::BYTE_W-1:0]      rsp_data,
   input logic [lfq_pkg::OUT_LEN_W-1:0]   rsp_len,
   input logic                            rsp_last
);
   import lfq_pkg::*;

   // A byte word answers with its status word on the very next cycle
   `LFQ_ASSERT(a_byte_answer, req_valid && req_ready && (req_action == ACT_BYTE) |=> rsp_valid && (rsp_kind == KIND_BYTE) && rsp_last, "byte word without status answer")

   // Only byte status words carry a nonzero status
   `LFQ_ASSERT(a_status_kind, rsp_valid && (rsp_kind != KIND_BYTE) |-> (rsp_status == STAT_OK), "status set on a line word")

   // Empty ring answer is a single zero word
   `LFQ_ASSERT(a_noline_word, rsp_valid && (rsp_kind == KIND_NOLINE) |-> rsp_last && (rsp_data == '0) && (rsp_len == '0), "malformed no-line word")

   // No request is taken while a line is still being drained
   `LFQ_ASSERT(a_drain_blocks, rsp_valid && (rsp_kind == KIND_LINE) && !rsp_last |-> !req_ready, "request taken mid drain")

   // Stalled response word holds
   `LFQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_kind) && $stable(rsp_last), "stalled response changed")

endmodule

bind crlf_line_framer_queue lfq_checker u_lfq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_action (req_bus.action),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_kind   (rsp_bus.result_kind),
   .rsp_status (rsp_bus.status),
   .rsp_data   (rsp_bus.data_byte),
   .rsp_len    (rsp_bus.line_length),
   .rsp_last   (rsp_bus.last)
);

`default_nettype wire
